@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the text console writer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TCW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TCW_ASSERT_NOW(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/tcw_pkg.sv @@
// Types, constants and helper functions of the text console writer
`default_nettype none
package tcw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DCOLOR = 2'd2;

  localparam logic [6:0] WIDTH_RST  = 7'd80;
  localparam logic [4:0] HEIGHT_RST = 5'd25;
  localparam logic [7:0] DCOLOR_RST = 8'd13;

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] BLINK    = 8'b1000_0000;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_FG    = 3'd1;
  localparam logic [2:0] KIND_BG    = 3'd2;
  localparam logic [2:0] KIND_COLOR = 3'd3;
  localparam logic [2:0] KIND_GLYPH = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE, PH_ESC, PH_ONE, PH_TWO_A, PH_TWO_B
  } esc_phase_t;

  typedef enum logic [1:0] {
    ACT_NONE, ACT_DRAW, ACT_SCROLL, ACT_DRAW_REDO
  } act_t;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_SCR_RD, ST_SCR_WR, ST_DRAW, ST_READ, ST_CLEAR, ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load_item;
    logic apply_dec;
    logic scan_start;
    logic scan_rd;
    logic scan_wr;
    logic clr_wr;
    logic init_wr;
    logic draw_wr;
    logic col_zero;
    logic rd_issue;
    logic out_load;
  } tcw_cmd_t;

  typedef struct packed {
    act_t act;
    logic col_full;
    logic win_empty;
    logic scan_last;
    logic init_last;
    logic out_busy;
  } tcw_sts_t;

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= "0" && b <= "9") v = 4'(b - "0");
    else if (b >= "a" && b <= "f") v = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") v = 4'(b - "A" + 8'd10);
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tcw_if.sv @@
// Request and result channel interfaces of the text console writer
`default_nettype none
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] byte_in;
  logic [4:0] read_row;
  logic [6:0] read_col;
  modport source (output valid, op, byte_in, read_row, read_col, input ready);
  modport sink (input valid, op, byte_in, read_row, read_col, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_entry;
  logic [6:0]  cursor_column;
  logic [7:0]  current_color;
  logic        escape_pending;
  modport source (output valid, read_entry, cursor_column, current_color, escape_pending,
                  input ready);
  modport sink (input valid, read_entry, cursor_column, current_color, escape_pending,
                output ready);
endinterface
`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
// Controller state machine of the text console writer
`default_nettype none
`include "assert_macros.svh"
module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_op,
  output logic               in_ready,
  input  wire tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t  cmd
);
  import tcw_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        ret_r, ret_nxt;    // scroll was started by a wrapping glyph
  logic        redo_r, redo_nxt;  // byte must be decoded again after the draw

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ret_r   <= 1'b0;
      redo_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      redo_r  <= redo_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    redo_nxt  = redo_r;
    unique case (state_r)
      ST_INIT: if (sts.init_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_op)
            OP_FEED:  state_nxt = ST_DECODE;
            OP_READ:  state_nxt = ST_READ;
            OP_CLEAR: state_nxt = sts.win_empty ? ST_DONE : ST_CLEAR;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DECODE: begin
        unique case (sts.act)
          ACT_NONE: state_nxt = ST_DONE;
          ACT_SCROLL: begin
            ret_nxt   = 1'b0;
            state_nxt = sts.win_empty ? ST_DONE : ST_SCR_RD;
          end
          default: begin
            redo_nxt = (sts.act == ACT_DRAW_REDO);
            if (sts.col_full) begin
              ret_nxt   = 1'b1;
              state_nxt = sts.win_empty ? ST_DRAW : ST_SCR_RD;
            end else begin
              state_nxt = ST_DRAW;
            end
          end
        endcase
      end
      ST_SCR_RD: state_nxt = ST_SCR_WR;
      ST_SCR_WR: begin
        if (sts.scan_last) state_nxt = ret_r ? ST_DRAW : ST_DONE;
        else state_nxt = ST_SCR_RD;
      end
      ST_DRAW: begin
        redo_nxt  = 1'b0;
        state_nxt = redo_r ? ST_DECODE : ST_DONE;
      end
      ST_READ:  state_nxt = ST_DONE;
      ST_CLEAR: if (sts.scan_last) state_nxt = ST_DONE;
      ST_DONE:  if (!sts.out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_INIT: cmd.init_wr = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_DECODE: begin
        cmd.apply_dec = 1'b1;
        if (sts.act == ACT_SCROLL || ((sts.act == ACT_DRAW || sts.act == ACT_DRAW_REDO)
            && sts.col_full)) begin
          cmd.scan_start = 1'b1;
          cmd.col_zero   = sts.win_empty;
        end
      end
      ST_SCR_RD: cmd.scan_rd = 1'b1;
      ST_SCR_WR: begin
        cmd.scan_wr  = 1'b1;
        cmd.col_zero = sts.scan_last;
      end
      ST_DRAW:  cmd.draw_wr = 1'b1;
      ST_READ:  cmd.rd_issue = 1'b1;
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_DONE:  cmd.out_load = !sts.out_busy;
      default: ;
    endcase
  end

  `TCW_ASSERT_NEXT(a_item_leaves_idle, cmd.load_item, state_r != ST_IDLE)
  `TCW_ASSERT_NOW(a_no_overwrite, cmd.out_load, !sts.out_busy)
  `TCW_ASSERT_NEXT(a_read_then_write, state_r == ST_SCR_RD, state_r == ST_SCR_WR)

endmodule
`default_nettype wire

@@ hdl/tcw_datapath.sv @@
// Datapath of the text console writer: cell memory, cursor, color, escape decoder
`default_nettype none
`include "assert_macros.svh"
module tcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire tcw_pkg::tcw_cmd_t                  cmd,
  output tcw_pkg::tcw_sts_t                       sts,
  input  wire logic [1:0]                         in_op,
  input  wire logic [7:0]                         in_byte,
  input  wire logic [4:0]                         in_row,
  input  wire logic [6:0]                         in_col,
  input  wire logic                               cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               out_ready,
  output logic                                    out_valid,
  output logic [15:0]                             out_entry,
  output logic [6:0]                              out_col,
  output logic [7:0]                              out_color,
  output logic                                    out_pend
);
  import tcw_pkg::*;

  localparam int DEPTH    = COLS * ROWS;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COLS_CAP = (COLS < 127) ? COLS : 127;
  localparam int ROWS_CAP = (ROWS < 31) ? ROWS : 31;

  logic [6:0]  width_r, col_r, dec_col, rcol_r, sc_r, eff_w;
  logic [4:0]  height_r, rrow_r, sr_r, eff_h;
  logic [7:0]  dcolor_r, color_r, dec_color, byte_r, glyph_r, dec_glyph;
  logic [2:0]  kind_r, dec_kind;
  logic [3:0]  hnib_r, dec_hnib, hx;
  logic [1:0]  op_r;
  esc_phase_t  phase_r, dec_phase;
  act_t        dec_act;
  logic [ADDR_W-1:0] base_r, init_r, scan_waddr, scan_raddr, draw_addr, item_addr;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_r, wdata;
  logic        inwin_r, inwin, last_col, last_row, draw_ok, we, re;
  logic        out_valid_r, out_pend_r;
  logic [15:0] out_entry_r;
  logic [6:0]  out_col_r;
  logic [7:0]  out_color_r;

  assign eff_w = (int'(width_r) < COLS) ? width_r : 7'(COLS_CAP);
  assign eff_h = (int'(height_r) < ROWS) ? height_r : 5'(ROWS_CAP);
  assign last_col = (sc_r == eff_w - 7'd1);
  assign last_row = (sr_r == eff_h - 5'd1);
  assign inwin = (rrow_r < eff_h) && (rcol_r < eff_w);
  assign draw_ok = (eff_h != 5'd0) && (col_r < eff_w);

  assign scan_waddr = base_r + ADDR_W'(sc_r);
  assign scan_raddr = last_row ? scan_waddr : base_r + ADDR_W'(COLS) + ADDR_W'(sc_r);
  assign draw_addr  = ADDR_W'((int'(eff_h) - 1) * COLS) + ADDR_W'(col_r);
  assign item_addr  = inwin ? ADDR_W'(int'(rrow_r) * COLS) + ADDR_W'(rcol_r) : '0;

  assign sts.act       = dec_act;
  assign sts.col_full  = (col_r >= eff_w);
  assign sts.win_empty = (eff_w == 7'd0) || (eff_h == 5'd0);
  assign sts.scan_last = last_col && last_row;
  assign sts.init_last = (init_r == ADDR_W'(DEPTH - 1));
  assign sts.out_busy  = out_valid_r && !out_ready;

  // escape and byte decoder
  always_comb begin
    hx        = hex_val(byte_r);
    dec_act   = ACT_NONE;
    dec_glyph = 8'd0;
    dec_phase = PH_IDLE;
    dec_kind  = kind_r;
    dec_hnib  = hnib_r;
    dec_color = color_r;
    dec_col   = col_r;
    if (phase_r != PH_IDLE && byte_r == CH_NUL) begin
      dec_phase = PH_IDLE;
    end else begin
      unique case (phase_r)
        PH_ESC: begin
          if (byte_r == "r") dec_color = dcolor_r;
          else if (byte_r == "i") dec_color = color_r ^ BLINK;
          else if (byte_r == "f" || byte_r == "b") begin
            dec_kind  = (byte_r == "f") ? KIND_FG : KIND_BG;
            dec_phase = PH_ONE;
          end else if (byte_r == "c" || byte_r == "g") begin
            dec_kind  = (byte_r == "c") ? KIND_COLOR : KIND_GLYPH;
            dec_phase = PH_TWO_A;
          end else begin
            dec_act = ACT_DRAW_REDO;
          end
        end
        PH_ONE: begin
          if (kind_r == KIND_FG) dec_color = {1'b0, color_r[6:4], hx};
          else dec_color = {1'b0, hx[2:0], color_r[3:0]};
        end
        PH_TWO_A: begin
          dec_hnib  = hx;
          dec_phase = PH_TWO_B;
        end
        PH_TWO_B: begin
          if (kind_r == KIND_COLOR) dec_color = {hnib_r, hx};
          else begin
            dec_act   = ACT_DRAW;
            dec_glyph = {hnib_r, hx};
          end
        end
        default: begin
          if (byte_r == CH_NUL) dec_act = ACT_NONE;
          else if (byte_r == CH_ESC) dec_phase = PH_ESC;
          else if (byte_r == CH_BS) begin
            if (col_r != 7'd0) dec_col = col_r - 7'd1;
          end else if (byte_r == CH_LF) dec_act = ACT_SCROLL;
          else begin
            dec_act = ACT_DRAW;
            if (byte_r > CH_SPACE && byte_r < CH_DEL) dec_glyph = byte_r;
          end
        end
      endcase
    end
  end

  always_comb begin
    we = cmd.init_wr || cmd.scan_wr || cmd.clr_wr || (cmd.draw_wr && draw_ok);
    re = cmd.scan_rd || cmd.rd_issue;
    raddr = cmd.rd_issue ? item_addr : scan_raddr;
    if (cmd.init_wr) begin
      waddr = init_r;
      wdata = 16'd0;
    end else if (cmd.draw_wr) begin
      waddr = draw_addr;
      wdata = {color_r, glyph_r};
    end else if (cmd.clr_wr) begin
      waddr = scan_waddr;
      wdata = {color_r, 8'd0};
    end else begin
      waddr = scan_waddr;
      wdata = last_row ? {dcolor_r, 8'd0} : rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      dcolor_r    <= DCOLOR_RST;
      col_r       <= 7'd0;
      color_r     <= DCOLOR_RST;
      phase_r     <= PH_IDLE;
      kind_r      <= KIND_NONE;
      hnib_r      <= 4'd0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WIDTH:  width_r  <= cfg_data[6:0];
          REG_HEIGHT: height_r <= cfg_data[4:0];
          REG_DCOLOR: dcolor_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.init_wr) init_r <= init_r + ADDR_W'(1);
      if (cmd.apply_dec) begin
        phase_r <= dec_phase;
        kind_r  <= dec_kind;
        hnib_r  <= dec_hnib;
        color_r <= dec_color;
      end
      if (cmd.col_zero) col_r <= 7'd0;
      else if (cmd.draw_wr) col_r <= col_r + 7'd1;
      else if (cmd.apply_dec) col_r <= dec_col;
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_op;
      byte_r <= in_byte;
      rrow_r <= in_row;
      rcol_r <= in_col;
    end
    if (cmd.apply_dec) glyph_r <= dec_glyph;
    if (cmd.rd_issue) inwin_r <= inwin;
    if (cmd.load_item || cmd.scan_start) begin
      sc_r   <= 7'd0;
      sr_r   <= 5'd0;
      base_r <= '0;
    end else if (cmd.scan_wr || cmd.clr_wr) begin
      if (last_col) begin
        sc_r   <= 7'd0;
        sr_r   <= sr_r + 5'd1;
        base_r <= base_r + ADDR_W'(COLS);
      end else begin
        sc_r <= sc_r + 7'd1;
      end
    end
    if (cmd.out_load) begin
      out_entry_r <= (op_r == OP_READ) ? (inwin_r ? rdata_r : {dcolor_r, 8'd0}) : 16'd0;
      out_col_r   <= col_r;
      out_color_r <= color_r;
      out_pend_r  <= (phase_r != PH_IDLE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_entry = out_entry_r;
  assign out_col   = out_col_r;
  assign out_color = out_color_r;
  assign out_pend  = out_pend_r;

  `TCW_ASSERT_NEXT(a_draw_advances, cmd.draw_wr && !cmd.col_zero, col_r == $past(col_r) + 7'd1)

endmodule
`default_nettype wire

@@ hdl/text_console_writer.sv @@
// Top level of the text console writer: controller, datapath and channel hookup
//
// Requests enter on in_ch (valid/ready); each yields one result on out_ch.
// op 0 feeds one byte to the console, op 1 reads one cell, op 2 clears the
// window to the current color. Configuration is a write-only port: cfg_we,
// cfg_idx (0 width, 1 height, 2 default color) and cfg_data.
// One request is worked at a time; in_ch.ready is high only when idle.
// A byte ending a bad escape can take two glyphs and two scrolls.
// The scroll is one read and one write of the cell memory per cell.
// After reset a clearing pass writes zero to all COLS*ROWS cells, one per
// cycle; no request is taken meanwhile.
// Results sit in an output register; a stalled receiver holds the block in
// its final step only while the previous result is still untaken, and
// in_ch.ready rises again once the new result is loaded.
`default_nettype none
module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tcw_in_if.sink                               in_ch,
  tcw_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [tcw_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;
  logic     in_ready;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tcw_datapath #(.COLS(COLS), .ROWS(ROWS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_ch.op),
    .in_byte   (in_ch.byte_in),
    .in_row    (in_ch.read_row),
    .in_col    (in_ch.read_col),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_entry (out_ch.read_entry),
    .out_col   (out_ch.cursor_column),
    .out_color (out_ch.current_color),
    .out_pend  (out_ch.escape_pending)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

@@ tb/tb_text_console_writer.sv @@
// Self-checking testbench for the text console writer: random and directed requests
`default_nettype none
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;

  typedef struct packed {
    logic [15:0] entry;
    logic [6:0]  column;
    logic [7:0]  color;
    logic        pending;
  } console_result_t;

  class console_scoreboard;
    logic [15:0] cells [COLS*ROWS];
    int unsigned cursor;
    logic [7:0] color;
    esc_phase_t phase;
    logic [2:0] kind;
    logic [3:0] high_hex;
    logic [6:0] win_w;
    logic [4:0] win_h;
    logic [7:0] dflt;
    console_result_t expected_results[$];
    int errors, n_req, n_feed, n_read, n_clear, n_scroll, n_res;

    function void reset_state();
      foreach (cells[i]) cells[i] = '0;
      win_w = WIDTH_RST;
      win_h = HEIGHT_RST;
      dflt = DCOLOR_RST;
      cursor = 0;
      color = DCOLOR_RST;
      phase = PH_IDLE;
      kind = KIND_NONE;
      high_hex = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_WIDTH:  win_w = val[6:0];
        REG_HEIGHT: win_h = val[4:0];
        REG_DCOLOR: dflt = val;
        default: ;
      endcase
    endfunction

    function int unsigned used_w();
      return (win_w < COLS) ? win_w : COLS;
    endfunction

    function int unsigned used_h();
      return (win_h < ROWS) ? win_h : ROWS;
    endfunction

    function logic [3:0] hex_digit(logic [7:0] b);
      if (b >= "0" && b <= "9") return 4'(b - "0");
      if (b >= "a" && b <= "f") return 4'(b - "a" + 10);
      if (b >= "A" && b <= "F") return 4'(b - "A" + 10);
      return 4'd0;
    endfunction

    function void scroll_window();
      int unsigned w, h;
      w = used_w();
      h = used_h();
      n_scroll++;
      for (int unsigned r = 0; r < h; r++)
        for (int unsigned c = 0; c < w; c++)
          cells[r*COLS + c] = (r + 1 < h) ? cells[(r+1)*COLS + c] : {dflt, 8'h00};
      cursor = 0;
    endfunction

    function void put_glyph(logic [7:0] g);
      if (cursor >= used_w()) scroll_window();
      if (used_h() > 0 && cursor < used_w())
        cells[(used_h()-1)*COLS + cursor] = {color, g};
      cursor++;
    endfunction

    function void plain_char(logic [7:0] b);
      if (b == CH_NUL) return;
      if (b == CH_ESC) begin
        phase = PH_ESC;
        return;
      end
      if (b == CH_BS) begin
        if (cursor > 0) cursor--;
        return;
      end
      if (b == CH_LF) begin
        scroll_window();
        return;
      end
      if (b > CH_SPACE && b < CH_DEL) put_glyph(b);
      else put_glyph(8'h00);
    endfunction

    function void feed_char(logic [7:0] b);
      logic [3:0] v;
      if (phase != PH_IDLE && b == CH_NUL) begin
        phase = PH_IDLE;
        return;
      end
      case (phase)
        PH_ESC: begin
          phase = PH_IDLE;
          if (b == "r") color = dflt;
          else if (b == "i") color ^= BLINK;
          else if (b == "f" || b == "b") begin
            kind = (b == "f") ? KIND_FG : KIND_BG;
            phase = PH_ONE;
          end else if (b == "c" || b == "g") begin
            kind = (b == "c") ? KIND_COLOR : KIND_GLYPH;
            phase = PH_TWO_A;
          end else begin
            // bad escape: blank glyph for the ESC, then reprocess the byte
            put_glyph(8'h00);
            plain_char(b);
          end
        end
        PH_ONE: begin
          phase = PH_IDLE;
          v = hex_digit(b);
          if (kind == KIND_FG) color = {1'b0, color[6:4], v};
          else color = {1'b0, v[2:0], color[3:0]};
        end
        PH_TWO_A: begin
          high_hex = hex_digit(b);
          phase = PH_TWO_B;
        end
        PH_TWO_B: begin
          phase = PH_IDLE;
          if (kind == KIND_COLOR) color = {high_hex, hex_digit(b)};
          else put_glyph({high_hex, hex_digit(b)});
        end
        default: begin
          phase = PH_IDLE;
          plain_char(b);
        end
      endcase
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] b, logic [4:0] row,
                               logic [6:0] col);
      console_result_t res;
      res.entry = '0;
      n_req++;
      if (op == OP_FEED) begin
        n_feed++;
        feed_char(b);
      end else if (op == OP_READ) begin
        n_read++;
        if (row < used_h() && col < used_w()) res.entry = cells[row*COLS + col];
        else res.entry = {dflt, 8'h00};
      end else if (op == OP_CLEAR) begin
        n_clear++;
        for (int unsigned r = 0; r < used_h(); r++)
          for (int unsigned c = 0; c < used_w(); c++)
            cells[r*COLS + c] = {color, 8'h00};
      end
      res.column = 7'(cursor);
      res.color = color;
      res.pending = (phase != PH_IDLE);
      expected_results.push_back(res);
    endfunction

    function void check_result(console_result_t got);
      console_result_t exp;
      n_res++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: %h", got);
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (got.entry !== exp.entry) begin
        $error("read_entry exp %h got %h", exp.entry, got.entry);
        errors++;
      end
      if (got.column !== exp.column) begin
        $error("cursor_column exp %0d got %0d", exp.column, got.column);
        errors++;
      end
      if (got.color !== exp.color) begin
        $error("current_color exp %h got %h", exp.color, got.color);
        errors++;
      end
      if (got.pending !== exp.pending) begin
        $error("escape_pending exp %b got %b", exp.pending, got.pending);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tcw_in_if in_ch();
  tcw_out_if out_ch();

  text_console_writer #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  console_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.read_entry, out_ch.cursor_column, out_ch.current_color,
                         out_ch.escape_pending});
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_req(logic [1:0] op, logic [7:0] b, logic [4:0] row, logic [6:0] col);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.byte_in <= b;
    in_ch.read_row <= row;
    in_ch.read_col <= col;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, b, row, col);
  endtask

  task automatic feed(logic [7:0] b);
    send_req(OP_FEED, b, 5'($urandom), 7'($urandom));
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reconfigure(logic [6:0] w, logic [4:0] h, logic [7:0] dc, int send_pct,
                             int recv_pct);
    drain();
    write_reg(REG_WIDTH, {1'b0, w});
    write_reg(REG_HEIGHT, {3'b0, h});
    write_reg(REG_DCOLOR, dc);
    cfg_we <= 1'b0;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [7:0] hex_char_or_junk();
    string digits = "0123456789abcdefABCDEF";
    if ($urandom_range(9) == 0) return 8'($urandom);
    return digits[$urandom_range(21)];
  endfunction

  task automatic random_traffic(int n);
    string letters = "rifbcg";
    logic [7:0] ltr;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 35) feed(8'($urandom_range(8'h7E, 8'h21)));
      else if (k < 47) begin
        feed(CH_ESC);
        ltr = ($urandom_range(9) == 0) ? 8'($urandom) : 8'(letters[$urandom_range(5)]);
        if ($urandom_range(15) == 0) ltr = CH_NUL;
        feed(ltr);
        if (ltr == "f" || ltr == "b") feed(hex_char_or_junk());
        if (ltr == "c" || ltr == "g") begin
          feed(hex_char_or_junk());
          feed(($urandom_range(15) == 0) ? CH_NUL : hex_char_or_junk());
        end
      end
      else if (k < 52) feed(CH_LF);
      else if (k < 57) feed(CH_BS);
      else if (k < 67) feed(8'($urandom));
      else if (k < 87) begin
        if ($urandom_range(1))
          send_req(OP_READ, 8'($urandom), 5'($urandom), 7'($urandom));
        else
          send_req(OP_READ, 8'($urandom), 5'($urandom_range(sb.used_h())),
                   7'($urandom_range(sb.used_w())));
      end
      else if (k < 93) send_req(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
      else send_req(2'd3, 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    in_ch.valid = 1'b0;
    in_ch.op = OP_FEED;
    in_ch.byte_in = '0;
    in_ch.read_row = '0;
    in_ch.read_col = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: byte classes, every escape, reads at the window edges
    feed(8'h21); feed(8'h7E); feed(CH_SPACE); feed(CH_DEL); feed(8'h80); feed(8'hFF);
    feed(CH_NUL); feed(CH_BS); feed(CH_ESC); feed("r"); feed(CH_ESC); feed("i");
    feed(CH_ESC); feed("f"); feed("A"); feed(CH_ESC); feed("b"); feed("7");
    feed(CH_ESC); feed("c"); feed("3"); feed("e"); feed(CH_ESC); feed("g");
    feed("F"); feed("f"); feed(CH_ESC); feed("z"); feed(CH_ESC); feed(CH_NUL);
    feed(CH_LF);
    send_req(OP_READ, 8'h00, 5'd24, 7'd1);
    send_req(OP_READ, 8'hFF, 5'd0, 7'd0);
    send_req(OP_READ, 8'h00, 5'd31, 7'd127);
    send_req(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_req(2'd3, 8'hFF, 5'd31, 7'd127);

    reconfigure(7'd127, 5'd31, 8'hFF, 85, 0);
    random_traffic(15);
    reconfigure(7'd1, 5'd1, 8'h00, 0, 85);
    random_traffic(50);
    reconfigure(7'd0, 5'd0, 8'h5A, 36, 36);
    random_traffic(30);
    reconfigure(7'd9, 5'd4, 8'($urandom), 0, 0);
    hold_cycles = 400;
    random_traffic(50);
    reconfigure(7'd13, 5'd6, 8'($urandom), 36, 36);
    random_traffic(50);
    reconfigure(7'd5, 5'd25, 8'($urandom), 85, 0);
    random_traffic(50);
    drain();

    $display("Covered %0d requests (%0d bytes, %0d reads, %0d clears), %0d scrolls,",
             sb.n_req, sb.n_feed, sb.n_read, sb.n_clear, sb.n_scroll);
    $display("%0d results checked over seven window and color settings.", sb.n_res);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
